### rtl/bis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

    // Default sizes of the box list and of one coordinate.
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    // IoU limit register: unsigned, 1 integer bit and 16 fraction bits; 1.0 or more disables suppression.
    localparam int                CFG_W         = 17;
    localparam int                LIM_FRAC      = 16;
    localparam logic [CFG_W-1:0]  IOU_LIMIT_RST = 17'd32768;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_LOAD,
        S_OUT_CHK,
        S_A_LOAD,
        S_A_AREA,
        S_IN_CHK,
        S_B_LOAD,
        S_B_AREA,
        S_INTER,
        S_UNION,
        S_TEST,
        S_MARK,
        S_EMIT_CHK,
        S_EMIT_GET
    } t_state;

    // Operation of the shared IoU arithmetic unit in the current cycle.
    typedef enum logic [2:0] {
        IOU_NOP,
        IOU_LOAD_A,
        IOU_AREA_A,
        IOU_LOAD_B,
        IOU_AREA_B,
        IOU_INTER,
        IOU_UNION,
        IOU_TEST
    } t_iou_op;

endpackage

`default_nettype wire

### rtl/bis_box_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bis_box_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/bis_iou_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module bis_iou_unit import bis_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire t_iou_op                   i_op,
    input  wire logic [4*COORD_BITS-1:0]   i_box,
    input  wire logic [CFG_W-1:0]          i_limit,
    output logic                           o_hit
);

    localparam int C      = COORD_BITS;
    localparam int AREA_W = 2 * C;
    localparam int UNI_W  = 2 * C + 1;
    localparam int PROD_W = UNI_W + LIM_FRAC;

    logic [C-1:0]      r_a_lx, r_a_ly, r_a_hx, r_a_hy;
    logic [C-1:0]      r_b_lx, r_b_ly, r_b_hx, r_b_hy;
    logic [AREA_W-1:0] r_area_a, r_area_b, r_inter;
    logic [C-1:0]      r_iw, r_ih;
    logic              r_ovl;
    logic [UNI_W-1:0]  r_uni;
    logic [PROD_W-1:0] r_prod;

    logic [C-1:0]        a_w, a_h, b_w, b_h;
    logic [C-1:0]        left, top, right, bottom;
    logic [UNI_W-1:0]    mul_a;
    logic [LIM_FRAC-1:0] mul_b;
    logic [PROD_W-1:0]   prod;

    // Extents clamp to zero for an inverted box.
    always_comb begin
        a_w    = (r_a_hx >= r_a_lx) ? r_a_hx - r_a_lx : '0;
        a_h    = (r_a_hy >= r_a_ly) ? r_a_hy - r_a_ly : '0;
        b_w    = (r_b_hx >= r_b_lx) ? r_b_hx - r_b_lx : '0;
        b_h    = (r_b_hy >= r_b_ly) ? r_b_hy - r_b_ly : '0;
        left   = (r_a_lx > r_b_lx) ? r_a_lx : r_b_lx;
        top    = (r_a_ly > r_b_ly) ? r_a_ly : r_b_ly;
        right  = (r_a_hx < r_b_hx) ? r_a_hx : r_b_hx;
        bottom = (r_a_hy < r_b_hy) ? r_a_hy : r_b_hy;
    end

    // Operand selection for the one shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            IOU_AREA_A: begin
                mul_a = UNI_W'(a_w);
                mul_b = LIM_FRAC'(a_h);
            end
            IOU_AREA_B: begin
                mul_a = UNI_W'(b_w);
                mul_b = LIM_FRAC'(b_h);
            end
            IOU_INTER: begin
                mul_a = UNI_W'(r_iw);
                mul_b = LIM_FRAC'(r_ih);
            end
            IOU_TEST: begin
                mul_a = r_uni;
                mul_b = i_limit[LIM_FRAC-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge i_clk) begin
        case (i_op)
            IOU_LOAD_A: begin
                r_a_lx <= i_box[0*C +: C];
                r_a_ly <= i_box[1*C +: C];
                r_a_hx <= i_box[2*C +: C];
                r_a_hy <= i_box[3*C +: C];
            end
            IOU_AREA_A: begin
                r_area_a <= prod[AREA_W-1:0];
            end
            IOU_LOAD_B: begin
                r_b_lx <= i_box[0*C +: C];
                r_b_ly <= i_box[1*C +: C];
                r_b_hx <= i_box[2*C +: C];
                r_b_hy <= i_box[3*C +: C];
            end
            IOU_AREA_B: begin
                r_area_b <= prod[AREA_W-1:0];
                r_ovl    <= (right >= left) && (bottom >= top);
                r_iw     <= right - left;
                r_ih     <= bottom - top;
            end
            IOU_INTER: begin
                r_inter <= r_ovl ? prod[AREA_W-1:0] : '0;
            end
            IOU_UNION: begin
                r_uni <= UNI_W'(r_area_a) + UNI_W'(r_area_b) - UNI_W'(r_inter);
            end
            IOU_TEST: begin
                r_prod <= prod;
            end
            default: begin
            end
        endcase
    end

    // A limit of 1.0 or more never suppresses, since the intersection never
    // exceeds the union. A zero union implies a zero intersection and fails.
    assign o_hit = !i_limit[CFG_W-1] &&
                   (PROD_W'({r_inter, {LIM_FRAC{1'b0}}}) > r_prod);

endmodule

`default_nettype wire

### rtl/box_iou_suppression.sv
`timescale 1ns / 1ps
`default_nettype none

// Greedy IoU non-maximum suppression. Boxes are given one per transfer in
// priority order (start high while busy is low) and the box with i_in_last
// set closes the list. Up to MAX_BOXES boxes are stored; boxes past that are
// dropped and every result of that list carries o_dropped_flag. After the
// closing box, busy stays high while a single shared multiplier tests each
// unsuppressed outer box against every later unsuppressed box, its pace set
// by that one multiplier and the single box memory read port. Survivors then
// come out in order, each shown with o_out_strobe high for exactly one
// cycle, the last one marked by o_out_last. The receiver cannot stall the
// block: every strobed result must be taken in the cycle it is shown. The IoU
// limit (17 bits, 16 fraction bits, reset 0.5) is written on the cfg
// channel, which is always ready, and may only be changed while busy is low.
module box_iou_suppression import bis_pkg::*; #(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [COORD_BITS-1:0] i_in_min_x,
    input  wire logic [COORD_BITS-1:0] i_in_min_y,
    input  wire logic [COORD_BITS-1:0] i_in_max_x,
    input  wire logic [COORD_BITS-1:0] i_in_max_y,
    input  wire logic                  i_in_last,

    output logic                       o_out_strobe,
    output logic [COORD_BITS-1:0]      o_out_min_x,
    output logic [COORD_BITS-1:0]      o_out_min_y,
    output logic [COORD_BITS-1:0]      o_out_max_x,
    output logic [COORD_BITS-1:0]      o_out_max_y,
    output logic                       o_out_last,
    output logic                       o_dropped_flag,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int BOX_W = 4 * C;
    localparam int AW    = $clog2(MAX_BOXES);
    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    // Control state.
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_total, n_total;
    logic                 r_ovf, n_ovf;
    logic [MAX_BOXES-1:0] r_marks, n_marks;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic                 r_pend_valid, n_pend_valid;
    logic                 r_out_strobe, n_out_strobe;
    logic [CFG_W-1:0]     r_limit;

    // Payload.
    logic [BOX_W-1:0]     r_pend_box, n_pend_box;
    logic [BOX_W-1:0]     r_out_box, n_out_box;
    logic                 r_out_last, n_out_last;
    logic                 r_out_drop, n_out_drop;

    logic                 accept;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic [BOX_W-1:0]     rd_data;
    t_iou_op              iou_op;
    logic                 hit;

    assign busy        = (r_state != S_LOAD);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // A box is written only while the store has room.
    assign wr_en = accept && (r_total < CNT_W'(MAX_BOXES));

    // The pair-test inner loop reads with the inner index; everything else
    // (outer box, emission) reads with the outer index.
    assign rd_addr = (r_state == S_IN_CHK) ? r_j[AW-1:0] : r_i[AW-1:0];

    bis_box_ram #(
        .DEPTH (MAX_BOXES),
        .WIDTH (BOX_W)
    ) u_box_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_total[AW-1:0]),
        .i_wr_data ({i_in_max_y, i_in_max_x, i_in_min_y, i_in_min_x}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bis_iou_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .i_clk   (i_clk),
        .i_op    (iou_op),
        .i_box   (rd_data),
        .i_limit (r_limit),
        .o_hit   (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_total      <= '0;
            r_ovf        <= 1'b0;
            r_marks      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_ovf        <= n_ovf;
            r_marks      <= n_marks;
            r_i          <= n_i;
            r_j          <= n_j;
            r_pend_valid <= n_pend_valid;
            r_out_strobe <= n_out_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= IOU_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_box <= n_pend_box;
        r_out_box  <= n_out_box;
        r_out_last <= n_out_last;
        r_out_drop <= n_out_drop;
    end

    // Sequencer: load, then for each unsuppressed outer box test every later
    // unsuppressed box, then emit survivors through a one-entry holding
    // register so that the final survivor can be marked as last.
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_ovf        = r_ovf;
        n_marks      = r_marks;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_valid = r_pend_valid;
        n_pend_box   = r_pend_box;
        n_out_strobe = 1'b0;
        n_out_box    = r_out_box;
        n_out_last   = r_out_last;
        n_out_drop   = r_out_drop;
        iou_op       = IOU_NOP;

        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    if (wr_en) begin
                        n_total = r_total + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_last) begin
                        n_i     = '0;
                        n_state = S_OUT_CHK;
                    end
                end
            end
            S_OUT_CHK: begin
                if (r_i == r_total) begin
                    n_i     = '0;
                    n_state = S_EMIT_CHK;
                end else if (r_marks[r_i[AW-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_state = S_A_LOAD;
                end
            end
            S_A_LOAD: begin
                iou_op  = IOU_LOAD_A;
                n_state = S_A_AREA;
            end
            S_A_AREA: begin
                iou_op  = IOU_AREA_A;
                n_j     = r_i + CNT_W'(1);
                n_state = S_IN_CHK;
            end
            S_IN_CHK: begin
                if (r_j == r_total) begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = S_OUT_CHK;
                end else if (r_marks[r_j[AW-1:0]]) begin
                    n_j = r_j + CNT_W'(1);
                end else begin
                    n_state = S_B_LOAD;
                end
            end
            S_B_LOAD: begin
                iou_op  = IOU_LOAD_B;
                n_state = S_B_AREA;
            end
            S_B_AREA: begin
                iou_op  = IOU_AREA_B;
                n_state = S_INTER;
            end
            S_INTER: begin
                iou_op  = IOU_INTER;
                n_state = S_UNION;
            end
            S_UNION: begin
                iou_op  = IOU_UNION;
                n_state = S_TEST;
            end
            S_TEST: begin
                iou_op  = IOU_TEST;
                n_state = S_MARK;
            end
            S_MARK: begin
                if (hit) begin
                    n_marks[r_j[AW-1:0]] = 1'b1;
                end
                n_j     = r_j + CNT_W'(1);
                n_state = S_IN_CHK;
            end
            S_EMIT_CHK: begin
                if (r_i == r_total) begin
                    // The held survivor is the final one of the list.
                    n_out_strobe = r_pend_valid;
                    n_out_box    = r_pend_box;
                    n_out_last   = 1'b1;
                    n_out_drop   = r_ovf;
                    n_pend_valid = 1'b0;
                    n_total      = '0;
                    n_ovf        = 1'b0;
                    n_marks      = '0;
                    n_state      = S_LOAD;
                end else if (r_marks[r_i[AW-1:0]]) begin
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_state = S_EMIT_GET;
                end
            end
            S_EMIT_GET: begin
                // A newer survivor exists, so the held one is not the last.
                if (r_pend_valid) begin
                    n_out_strobe = 1'b1;
                    n_out_box    = r_pend_box;
                    n_out_last   = 1'b0;
                    n_out_drop   = r_ovf;
                end
                n_pend_box   = rd_data;
                n_pend_valid = 1'b1;
                n_i          = r_i + CNT_W'(1);
                n_state      = S_EMIT_CHK;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_out_strobe   = r_out_strobe;
    assign o_out_min_x    = r_out_box[0*C +: C];
    assign o_out_min_y    = r_out_box[1*C +: C];
    assign o_out_max_x    = r_out_box[2*C +: C];
    assign o_out_max_y    = r_out_box[3*C +: C];
    assign o_out_last     = r_out_last;
    assign o_dropped_flag = r_out_drop;

endmodule

`default_nettype wire
